// File: hw/rtl/lcd_controller_serial_frame_writer_assert.svh
// assertion macros used by the serial frame writer checker
`ifndef LCD_CONTROLLER_SERIAL_FRAME_WRITER_ASSERT_SVH
`define LCD_CONTROLLER_SERIAL_FRAME_WRITER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LCDSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcdsw assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LCDSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcdsw assertion failed");

`endif

// File: hw/rtl/lcdsw_pkg.sv
// shared types and constants of the lcd serial frame writer
`timescale 1ns / 1ps
package lcdsw_pkg;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CMD_W      = 8;
    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned FRAME_BITS = 12;
    localparam int unsigned CNT_W      = 4;

    // bit runs per request type
    localparam int unsigned CMD_BITS       = MODE_W + CMD_W + 1;
    localparam int unsigned RAM_START_BITS = MODE_W + ADDR_W;
    localparam int unsigned NIBBLE_BITS    = NIB_W;

    localparam logic [MODE_W-1:0] MODE_CMD = 3'b100;
    localparam logic [MODE_W-1:0] MODE_WR  = 3'b101;

    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_COMMAND    = 2'd0,
        OP_RAM_START  = 2'd1,
        OP_RAM_NIBBLE = 2'd2
    } t_opcode;

    // one serial run, bits left aligned, sent from the msb
    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic [CNT_W-1:0]      count;
        logic                  begin_mark;
        logic                  finish_mark;
    } t_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// File: hw/rtl/lcdsw_front.sv
// front end: accepts requests, tracks the open write frame, builds bit runs
`timescale 1ns / 1ps
module lcdsw_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lcdsw_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [lcdsw_pkg::CMD_W-1:0]     i_command_byte,
    input  logic [lcdsw_pkg::ADDR_W-1:0]    i_ram_address,
    input  logic [lcdsw_pkg::NIB_W-1:0]     i_nibble_value,
    input  logic                            i_final_nibble,
    input  lcdsw_pkg::t_queue_status        i_queue_status,
    output logic                            o_push,
    output lcdsw_pkg::t_desc                o_desc
);
    import lcdsw_pkg::*;

    logic r_frame_open;
    logic n_frame_open;
    logic accept;

    assign o_in_stall = i_queue_status.full;
    assign accept     = i_in_valid && !i_queue_status.full;

    always_comb begin
        n_frame_open = r_frame_open;
        o_push       = 1'b0;
        o_desc       = '0;
        case (t_opcode'(i_opcode))
            OP_COMMAND: begin
                o_desc.bits        = {MODE_CMD, i_command_byte, 1'b0};
                o_desc.count       = CNT_W'(CMD_BITS);
                o_desc.begin_mark  = 1'b1;
                o_desc.finish_mark = 1'b1;
                o_push             = accept;
                if (accept) begin
                    n_frame_open = 1'b0;
                end
            end
            OP_RAM_START: begin
                o_desc.bits        = {MODE_WR, i_ram_address,
                                      {(FRAME_BITS - RAM_START_BITS){1'b0}}};
                o_desc.count       = CNT_W'(RAM_START_BITS);
                o_desc.begin_mark  = 1'b1;
                o_desc.finish_mark = 1'b0;
                o_push             = accept;
                if (accept) begin
                    n_frame_open = 1'b1;
                end
            end
            OP_RAM_NIBBLE: begin
                // data goes out lsb first
                o_desc.bits        = {i_nibble_value[0], i_nibble_value[1],
                                      i_nibble_value[2], i_nibble_value[3],
                                      {(FRAME_BITS - NIBBLE_BITS){1'b0}}};
                o_desc.count       = CNT_W'(NIBBLE_BITS);
                o_desc.begin_mark  = 1'b0;
                o_desc.finish_mark = i_final_nibble;
                // nibble outside a write frame is dropped
                o_push             = accept && r_frame_open;
                if (accept && r_frame_open && i_final_nibble) begin
                    n_frame_open = 1'b0;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
        end
    end

endmodule

// File: hw/rtl/lcdsw_queue.sv
// short descriptor queue between front and back end
`timescale 1ns / 1ps
module lcdsw_queue #(
    parameter int unsigned DEPTH = lcdsw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  lcdsw_pkg::t_desc          i_desc,
    input  logic                      i_pop,
    output lcdsw_pkg::t_desc          o_desc,
    output lcdsw_pkg::t_queue_status  o_status
);
    import lcdsw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_QW'(DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_desc         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/lcdsw_back.sv
// back end: shifts bit runs out one write strobe per cycle while the output is not stalled
`timescale 1ns / 1ps
module lcdsw_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lcdsw_pkg::t_queue_status  i_queue_status,
    input  lcdsw_pkg::t_desc          i_desc,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_data_bit,
    output logic                      o_frame_begin,
    output logic                      o_frame_finish,
    output logic                      o_last
);
    import lcdsw_pkg::*;

    logic [FRAME_BITS-1:0] r_shift;
    logic [CNT_W-1:0]      r_left;
    logic                  r_finish;
    logic                  r_out_valid;
    logic                  r_data_bit;
    logic                  r_frame_begin;
    logic                  r_frame_finish;
    logic                  r_last;
    logic                  load_ok;
    logic                  run_busy;
    logic                  first_last;
    logic                  run_last;

    assign load_ok    = !r_out_valid || !i_out_stall;
    assign run_busy   = (r_left != '0);
    assign o_pop      = load_ok && !run_busy && !i_queue_status.empty;
    assign first_last = (i_desc.count == CNT_W'(1));
    assign run_last   = (r_left == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else if (load_ok) begin
            if (run_busy) begin
                r_out_valid <= 1'b1;
                r_left      <= r_left - 1'b1;
            end else if (!i_queue_status.empty) begin
                r_out_valid <= 1'b1;
                r_left      <= i_desc.count - 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            if (run_busy) begin
                r_data_bit     <= r_shift[FRAME_BITS-1];
                r_frame_begin  <= 1'b0;
                r_frame_finish <= run_last && r_finish;
                r_last         <= run_last;
                r_shift        <= {r_shift[FRAME_BITS-2:0], 1'b0};
            end else if (!i_queue_status.empty) begin
                r_data_bit     <= i_desc.bits[FRAME_BITS-1];
                r_frame_begin  <= i_desc.begin_mark;
                r_frame_finish <= first_last && i_desc.finish_mark;
                r_last         <= first_last;
                r_shift        <= {i_desc.bits[FRAME_BITS-2:0], 1'b0};
                r_finish       <= i_desc.finish_mark;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_bit     = r_data_bit;
    assign o_frame_begin  = r_frame_begin;
    assign o_frame_finish = r_frame_finish;
    assign o_last         = r_last;

endmodule

// File: hw/rtl/lcd_controller_serial_frame_writer.sv
// top level of the three-wire segment lcd serial frame writer
`timescale 1ns / 1ps
// usage
//   input channel (i_in_valid / o_in_stall) takes one request per accept:
//   a command frame, a display ram write start or one ram data nibble
//   output channel (o_out_valid / i_out_stall) gives one write strobe per
//   accept: the data line level plus chip select framing marks
//   a command request gives 12 strobes (mode 100, command msb first, a zero),
//   a ram start gives 9 (mode 101, address msb first) and leaves a write
//   frame open, a nibble gives 4 (data lsb first) and closes the frame when
//   flagged final; a nibble with no open frame and an unused opcode give none
//   a request is written into the queue and its first strobe then loaded
//   into the output register; throughput: one strobe per cycle while the
//   output is not stalled, from the single output register; runs of
//   consecutive requests follow each other with no gap
//   the front end keeps taking requests while the queue has room, so a
//   stalled receiver backs up the queue and then stalls the sender
//   a stalled strobe holds its value until taken
//   reset (synchronous, active low) empties the queue, drops any strobe in
//   flight and closes the write frame
module lcd_controller_serial_frame_writer #(
    parameter int unsigned QUEUE_DEPTH = lcdsw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lcdsw_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [lcdsw_pkg::CMD_W-1:0]     i_command_byte,
    input  logic [lcdsw_pkg::ADDR_W-1:0]    i_ram_address,
    input  logic [lcdsw_pkg::NIB_W-1:0]     i_nibble_value,
    input  logic                            i_final_nibble,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_data_bit,
    output logic                            o_frame_begin,
    output logic                            o_frame_finish,
    output logic                            o_last
);
    import lcdsw_pkg::*;

    // front to queue
    logic          push;
    t_desc         push_desc;
    // queue to back
    logic          pop;
    t_desc         head_desc;
    t_queue_status queue_status;

    // classify requests and track the open write frame
    lcdsw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_command_byte (i_command_byte),
        .i_ram_address  (i_ram_address),
        .i_nibble_value (i_nibble_value),
        .i_final_nibble (i_final_nibble),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    // decouples request intake from strobe output
    lcdsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_desc   (head_desc),
        .o_status (queue_status)
    );

    // serializer with registered output
    lcdsw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_status (queue_status),
        .i_desc         (head_desc),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_bit     (o_data_bit),
        .o_frame_begin  (o_frame_begin),
        .o_frame_finish (o_frame_finish),
        .o_last         (o_last)
    );

endmodule

// File: hw/rtl/lcdsw_checker.sv
// port level checks of the serial frame writer, bound to the top level
`timescale 1ns / 1ps
`include "lcd_controller_serial_frame_writer_assert.svh"
module lcdsw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_data_bit,
    input logic o_frame_begin,
    input logic o_frame_finish,
    input logic o_last
);

    logic       stalled;
    logic [3:0] strobe;

    assign stalled = o_out_valid && i_out_stall;
    assign strobe  = {o_data_bit, o_frame_begin, o_frame_finish, o_last};

    // a stalled strobe is held unchanged
    `LCDSW_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(strobe))

    // chip select only rises after the last strobe of a request
    `LCDSW_ASSERT_NOW(a_finish_on_last, i_clk, i_rst_n, o_out_valid && o_frame_finish, o_last)

    // no frame is a single strobe long
    `LCDSW_ASSERT_NOW(a_begin_not_finish, i_clk, i_rst_n, o_out_valid && o_frame_begin, !o_frame_finish)

    // nothing is presented right after reset
    `LCDSW_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !o_out_valid)

endmodule

bind lcd_controller_serial_frame_writer lcdsw_checker u_lcdsw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_data_bit     (o_data_bit),
    .o_frame_begin  (o_frame_begin),
    .o_frame_finish (o_frame_finish),
    .o_last         (o_last)
);
